// ===== rtl/sol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sol_pkg
// shared types, constants, coefficient and channel-group helpers for the
// multichannel second-order low-pass filter
// ----------------------------------------------------------------------------
package sol_pkg;

  localparam int SAMPLE_W = 32;
  localparam int TIME_W   = 48;
  localparam int NVAL     = 7;
  localparam int NCH      = 13;
  localparam int CH_W     = 4;
  localparam int K_W      = 20;
  localparam int XI_W     = 15;
  localparam int OMEGA_W  = 16;
  localparam int MINT_W   = 24;
  localparam int COEF_W   = 27;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = 64;
  localparam int P_W      = TIME_W + OMEGA_W;
  localparam int CFG_IDX_W = 3;

  // k = floor(p * 4 / 15625) = (p * ceil(2^48 / 15625)) >> 46 for p < 2^32
  localparam int PQ_W      = 32;
  localparam int RCP_LO_W  = 18;
  localparam int RCP_HI_W  = 17;
  localparam int PL_W      = PQ_W + RCP_LO_W;
  localparam int PH_W      = PQ_W + RCP_HI_W;
  localparam int RCP_SUM_W = PH_W + RCP_LO_W;
  localparam int RCP_SHIFT = 46;

  localparam logic [K_W-1:0]      K_MAX     = {K_W{1'b1}};
  localparam logic [P_W-1:0]      P_SAT     = P_W'(64'd4096000000);
  localparam logic [RCP_LO_W-1:0] RCP_LO    = RCP_LO_W'(124974);
  localparam logic [RCP_HI_W-1:0] RCP_HI    = RCP_HI_W'(68719);
  localparam logic [CH_W-1:0]     CH_LAST   = CH_W'(NCH - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_ANG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_ANG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_LIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT    = 3'd4;

  localparam logic KIND_POSE  = 1'b0;
  localparam logic KIND_TWIST = 1'b1;

  typedef struct packed {
    logic [OMEGA_W-1:0] cutoff_ang;
    logic [OMEGA_W-1:0] cutoff_lin;
    logic [XI_W-1:0]    damp_ang;
    logic [XI_W-1:0]    damp_lin;
    logic [MINT_W-1:0]  min_interval;
  } sol_cfg_t;

  // the dt field holds dt for a twist
  typedef struct packed {
    logic                            kind;
    logic [TIME_W-1:0]               dt;
    logic [NVAL-1:0][SAMPLE_W-1:0]   value;
  } sol_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } sol_coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_COEF1,
    ST_COEF2,
    ST_MAC,
    ST_OUT
  } sol_state_t;

  function automatic sol_coef_t calc_coef(input logic [2*K_W-1:0] kk,
                                          input logic [K_W+XI_W-1:0] kxi);
    logic [2*K_W-1:0]     kk_rnd;
    logic [K_W+XI_W-1:0]  kxi_rnd;
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] kx;
    sol_coef_t r;
    kk_rnd  = kk + (2*K_W)'(32768);
    kxi_rnd = kxi + (K_W+XI_W)'(8192);
    c0 = COEF_W'($signed({1'b0, kk_rnd[2*K_W-1:16]}));
    kx = COEF_W'($signed({1'b0, kxi_rnd[K_W+XI_W-1:14]}));
    r.c0 = c0;
    r.c1 = COEF_W'(131072) - (kx <<< 1);
    r.c2 = COEF_W'(65536) - c0 - r.c1;
    return r;
  endfunction

  function automatic logic is_ang(input logic [CH_W-1:0] ch);
    return (ch < CH_W'(3)) || (ch >= CH_W'(6) && ch < CH_W'(10));
  endfunction

endpackage

// ===== rtl/sol_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sol_front
// configuration registers, item classification and twist interval gate
// ----------------------------------------------------------------------------
module sol_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sol_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sol_pkg::MINT_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [sol_pkg::TIME_W-1:0]   in_time,
  input  logic [sol_pkg::NVAL-1:0][sol_pkg::SAMPLE_W-1:0] in_value,
  input  logic                         q_full,
  output logic                         q_push,
  output sol_pkg::sol_item_t           q_item,
  output sol_pkg::sol_cfg_t            cfg
);

  sol_pkg::sol_cfg_t            cfg_r;
  logic [sol_pkg::TIME_W-1:0]   last_time_r;
  logic [sol_pkg::TIME_W-1:0]   dt;
  logic                         pass;
  logic                         acc;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;
  assign dt        = in_time - last_time_r;
  assign pass      = (in_time > last_time_r) &&
                     (dt > sol_pkg::TIME_W'(cfg_r.min_interval));

  always_comb begin
    q_item.kind  = in_kind;
    q_item.dt    = dt;
    q_item.value = in_value;
    q_push = acc && ((in_kind == sol_pkg::KIND_POSE) || pass);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_ang   <= 16'd2560;
      cfg_r.cutoff_lin   <= 16'd853;
      cfg_r.damp_ang     <= 15'd15729;
      cfg_r.damp_lin     <= 15'd15729;
      cfg_r.min_interval <= 24'd31250;
      last_time_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sol_pkg::CFG_CUTOFF_ANG: cfg_r.cutoff_ang   <= cfg_data[15:0];
          sol_pkg::CFG_CUTOFF_LIN: cfg_r.cutoff_lin   <= cfg_data[15:0];
          sol_pkg::CFG_DAMP_ANG:   cfg_r.damp_ang     <= cfg_data[14:0];
          sol_pkg::CFG_DAMP_LIN:   cfg_r.damp_lin     <= cfg_data[14:0];
          sol_pkg::CFG_MIN_INT:    cfg_r.min_interval <= cfg_data;
          default: ;
        endcase
      end
      if (acc && in_kind == sol_pkg::KIND_TWIST && pass) begin
        last_time_r <= in_time;
      end
    end
  end

endmodule

// ===== rtl/sol_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sol_fifo
// two-entry queue between classification and filtering
// ----------------------------------------------------------------------------
module sol_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sol_pkg::sol_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output sol_pkg::sol_item_t pop_item
);

  sol_pkg::sol_item_t mem_r [2];
  logic               wp_r;
  logic               rp_r;
  logic [1:0]         cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/sol_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sol_back
// coefficient computation and per-channel filter sequencing on one mac unit
// ----------------------------------------------------------------------------
module sol_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sol_pkg::sol_cfg_t             cfg,
  input  logic                          q_avail,
  input  sol_pkg::sol_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sol_pkg::CH_W-1:0]      out_channel,
  output logic [sol_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic                          out_clipped,
  output logic                          out_last
);

  localparam int SW = sol_pkg::SAMPLE_W;
  localparam int KW = sol_pkg::K_W;

  sol_pkg::sol_state_t state_r, state_nxt;

  logic signed [SW-1:0] pose_r [sol_pkg::NVAL];
  logic signed [SW-1:0] xv_r   [6];
  logic signed [SW-1:0] h1_r   [sol_pkg::NCH];
  logic signed [SW-1:0] h2_r   [sol_pkg::NCH];
  logic [sol_pkg::TIME_W-1:0] dt_r;
  logic [sol_pkg::P_W-1:0]    pa_r, pl_r;
  logic                       sa_r, sl_r;
  logic [sol_pkg::PL_W-1:0]   pla_r, pll_r;
  logic [KW-1:0]              qa_r, ql_r;
  logic [2*KW-1:0]            kka_r, kkl_r;
  logic [KW+sol_pkg::XI_W-1:0] kxa_r, kxl_r;
  sol_pkg::sol_coef_t         ca_r, cl_r;
  logic [sol_pkg::CH_W-1:0]   ch_r;
  logic [1:0]                 sub_r;
  logic signed [sol_pkg::PROD_W-1:0] mul_r;
  logic signed [sol_pkg::ACC_W-1:0]  acc_r;
  logic                       ov_r;
  logic [sol_pkg::CH_W-1:0]   och_r;
  logic [SW-1:0]              oy_r;
  logic                       oclip_r, olast_r;

  logic [sol_pkg::PH_W-1:0]      pha, phl;
  logic [sol_pkg::RCP_SUM_W-1:0] qsa, qsl;
  logic [KW-1:0]              ka, kl;
  sol_pkg::sol_coef_t         csel;
  logic signed [sol_pkg::COEF_W-1:0] cval;
  logic signed [SW-1:0]       xsel, vsel;
  logic signed [sol_pkg::PROD_W-1:0] prod;
  logic signed [sol_pkg::ACC_W-1:0]  tot, yfull;
  logic signed [SW-1:0]       ysat;
  logic                       clip;
  logic                       out_free;

  assign out_valid    = ov_r;
  assign out_channel  = och_r;
  assign out_filtered = oy_r;
  assign out_clipped  = oclip_r;
  assign out_last     = olast_r;
  assign out_free     = !ov_r || out_ready;

  always_comb begin
    pha  = sol_pkg::PH_W'(pa_r[sol_pkg::PQ_W-1:0]) * sol_pkg::PH_W'(sol_pkg::RCP_HI);
    phl  = sol_pkg::PH_W'(pl_r[sol_pkg::PQ_W-1:0]) * sol_pkg::PH_W'(sol_pkg::RCP_HI);
    qsa  = {pha, sol_pkg::RCP_LO_W'(0)} + sol_pkg::RCP_SUM_W'(pla_r);
    qsl  = {phl, sol_pkg::RCP_LO_W'(0)} + sol_pkg::RCP_SUM_W'(pll_r);
    ka   = sa_r ? sol_pkg::K_MAX : qa_r;
    kl   = sl_r ? sol_pkg::K_MAX : ql_r;
    csel = sol_pkg::is_ang(ch_r) ? ca_r : cl_r;
    xsel = (ch_r < sol_pkg::CH_W'(6)) ? xv_r[3'(ch_r)]
                                      : pose_r[3'(ch_r - sol_pkg::CH_W'(6))];
    case (sub_r)
      2'd0:    begin cval = csel.c0; vsel = xsel;      end
      2'd1:    begin cval = csel.c1; vsel = h1_r[ch_r]; end
      default: begin cval = csel.c2; vsel = h2_r[ch_r]; end
    endcase
    prod  = sol_pkg::PROD_W'(cval) * sol_pkg::PROD_W'(vsel);
    tot   = acc_r + sol_pkg::ACC_W'(mul_r) + sol_pkg::ACC_W'(32768);
    yfull = tot >>> 16;
    clip  = 1'b0;
    ysat  = yfull[SW-1:0];
    if (yfull > sol_pkg::ACC_W'(64'sd2147483647)) begin
      ysat = {1'b0, {(SW-1){1'b1}}};
      clip = 1'b1;
    end else if (yfull < -sol_pkg::ACC_W'(64'sd2147483648)) begin
      ysat = {1'b1, {(SW-1){1'b0}}};
      clip = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      sol_pkg::ST_IDLE: begin
        q_pop = q_avail;
        if (q_avail && q_item.kind == sol_pkg::KIND_TWIST) state_nxt = sol_pkg::ST_MUL;
      end
      sol_pkg::ST_MUL:   state_nxt = sol_pkg::ST_DINIT;
      sol_pkg::ST_DINIT: state_nxt = sol_pkg::ST_DIV;
      sol_pkg::ST_DIV:   state_nxt = sol_pkg::ST_COEF1;
      sol_pkg::ST_COEF1: state_nxt = sol_pkg::ST_COEF2;
      sol_pkg::ST_COEF2: state_nxt = sol_pkg::ST_MAC;
      sol_pkg::ST_MAC: begin
        if (sub_r == 2'd2) state_nxt = sol_pkg::ST_OUT;
      end
      sol_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = (ch_r == sol_pkg::CH_LAST) ? sol_pkg::ST_IDLE : sol_pkg::ST_MAC;
        end
      end
      default: state_nxt = sol_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      for (int i = 0; i < sol_pkg::NVAL; i++) pose_r[i] <= '0;
      for (int i = 0; i < sol_pkg::NCH; i++) begin
        h1_r[i] <= '0;
        h2_r[i] <= '0;
      end
    end else begin
      if (ov_r && out_ready && state_r != sol_pkg::ST_OUT) ov_r <= 1'b0;
      case (state_r)
        sol_pkg::ST_IDLE: begin
          if (q_avail) begin
            if (q_item.kind == sol_pkg::KIND_POSE) begin
              for (int i = 0; i < sol_pkg::NVAL; i++) pose_r[i] <= q_item.value[i];
            end else begin
              for (int i = 0; i < 6; i++) xv_r[i] <= q_item.value[i];
              dt_r <= q_item.dt;
            end
          end
        end
        sol_pkg::ST_MUL: begin
          pa_r <= sol_pkg::P_W'(dt_r) * sol_pkg::P_W'(cfg.cutoff_ang);
          pl_r <= sol_pkg::P_W'(dt_r) * sol_pkg::P_W'(cfg.cutoff_lin);
        end
        sol_pkg::ST_DINIT: begin
          sa_r  <= (pa_r >= sol_pkg::P_SAT);
          sl_r  <= (pl_r >= sol_pkg::P_SAT);
          pla_r <= sol_pkg::PL_W'(pa_r[sol_pkg::PQ_W-1:0]) * sol_pkg::PL_W'(sol_pkg::RCP_LO);
          pll_r <= sol_pkg::PL_W'(pl_r[sol_pkg::PQ_W-1:0]) * sol_pkg::PL_W'(sol_pkg::RCP_LO);
        end
        sol_pkg::ST_DIV: begin
          qa_r <= qsa[sol_pkg::RCP_SHIFT +: KW];
          ql_r <= qsl[sol_pkg::RCP_SHIFT +: KW];
        end
        sol_pkg::ST_COEF1: begin
          kka_r <= (2*KW)'(ka) * (2*KW)'(ka);
          kkl_r <= (2*KW)'(kl) * (2*KW)'(kl);
          kxa_r <= (KW+sol_pkg::XI_W)'(ka) * (KW+sol_pkg::XI_W)'(cfg.damp_ang);
          kxl_r <= (KW+sol_pkg::XI_W)'(kl) * (KW+sol_pkg::XI_W)'(cfg.damp_lin);
        end
        sol_pkg::ST_COEF2: begin
          ca_r  <= sol_pkg::calc_coef(kka_r, kxa_r);
          cl_r  <= sol_pkg::calc_coef(kkl_r, kxl_r);
          ch_r  <= '0;
          sub_r <= '0;
        end
        sol_pkg::ST_MAC: begin
          mul_r <= prod;
          if (sub_r == 2'd0) acc_r <= '0;
          else if (sub_r == 2'd1) acc_r <= sol_pkg::ACC_W'(mul_r);
          else acc_r <= acc_r + sol_pkg::ACC_W'(mul_r);
          sub_r <= sub_r + 2'd1;
        end
        sol_pkg::ST_OUT: begin
          if (out_free) begin
            ov_r       <= 1'b1;
            och_r      <= ch_r;
            oy_r       <= ysat;
            oclip_r    <= clip;
            olast_r    <= (ch_r == sol_pkg::CH_LAST);
            h1_r[ch_r] <= ysat;
            h2_r[ch_r] <= h1_r[ch_r];
            ch_r       <= ch_r + sol_pkg::CH_W'(1);
            sub_r      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/second_order_lowpass_multichannel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_lowpass_multichannel_top
// an accepted twist beat yields 13 result beats
// (shared 27x32 mac, 3 taps + store)
// the back end pops no new beat until the 13-channel mac sequence is done
// pose beats only load the pose registers; two beats queue between front and back
// rst_n synchronous active low: registers to defaults, pose and history to zero
// ----------------------------------------------------------------------------
module second_order_lowpass_multichannel_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [271:0] in_tdata,   // time_us[47:0], value_0 .. value_6
  input  logic [0:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // filtered
  output logic [4:0]   out_tuser,  // channel[3:0], clipped
  output logic         out_tlast
);

  logic [sol_pkg::NVAL-1:0][sol_pkg::SAMPLE_W-1:0] in_value;
  sol_pkg::sol_cfg_t  cfg;
  sol_pkg::sol_item_t push_item, pop_item;
  logic               q_full, q_push, q_pop, q_avail;

  assign in_value = in_tdata[271:48];

  sol_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser[0]),
    .in_time   (in_tdata[47:0]),
    .in_value  (in_value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item),
    .cfg       (cfg)
  );

  sol_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_item  (pop_item)
  );

  sol_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_avail      (q_avail),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_channel  (out_tuser[3:0]),
    .out_filtered (out_tdata),
    .out_clipped  (out_tuser[4]),
    .out_last     (out_tlast)
  );

endmodule

// ===== dv/second_order_lowpass_multichannel_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_lowpass_multichannel_top_test
// drives pose and twist beats and config writes with random gaps and stalls,
// predicts the 13 filtered channels per accepted twist and checks every
// result beat field by field, in order
// ----------------------------------------------------------------------------
module second_order_lowpass_multichannel_top_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int NVAL   = sol_pkg::NVAL;
  localparam int NCH    = sol_pkg::NCH;
  localparam int TIME_W = sol_pkg::TIME_W;
  localparam int K_W    = sol_pkg::K_W;
  localparam logic [sol_pkg::CFG_IDX_W-1:0] CFG_NONE_LO = 3'd5;
  localparam logic [sol_pkg::CFG_IDX_W-1:0] CFG_NONE_HI = 3'd7;

  typedef struct {
    logic [sol_pkg::CH_W-1:0]     ch;
    logic [sol_pkg::SAMPLE_W-1:0] val;
    logic                         clip;
    logic                         last;
  } chan_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [271:0] in_tdata = '0;   // time_us[47:0], value_0 .. value_6
  logic [0:0]   in_tuser = '0;   // kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;       // filtered
  logic [4:0]   out_tuser;       // channel[3:0], clipped
  logic         out_tlast;

  chan_res_t   pending_res[$];
  int          errors = 0;
  int          cycles = 0;
  int          out_hold = 0;
  bit          calm = 1'b0;

  // predictor state
  logic [sol_pkg::OMEGA_W-1:0] p_cut_ang, p_cut_lin;
  logic [sol_pkg::XI_W-1:0]    p_damp_ang, p_damp_lin;
  logic [sol_pkg::MINT_W-1:0]  p_min_int;
  longint              p_pose[NVAL];
  longint              p_y1[NCH];
  longint              p_y2[NCH];
  logic [TIME_W-1:0]   p_last_time;

  second_order_lowpass_multichannel_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< 8;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 4;
    endcase
  endfunction

  function automatic logic [K_W-1:0] k_of(longint unsigned dt, longint unsigned omega);
    longint unsigned p, q, r;
    p = dt * omega;
    q = p / 1000000;
    r = p % 1000000;
    if (q >= 4096) return sol_pkg::K_MAX;
    return K_W'(q * 256 + (r * 256) / 1000000);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic predict_beat(logic kind, logic [TIME_W-1:0] t, logic [31:0] v[NVAL]);
    longint unsigned dt, k, xi;
    longint c[2][3], kx, acc, y, xin;
    chan_res_t res;
    int g;
    if (kind == sol_pkg::KIND_POSE) begin
      for (int i = 0; i < NVAL; i++) p_pose[i] = longint'($signed(v[i]));
      return;
    end
    if (t <= p_last_time || t - p_last_time <= TIME_W'(p_min_int)) return;
    dt = 64'(t - p_last_time);
    p_last_time = t;
    for (int s = 0; s < 2; s++) begin
      k = 64'(k_of(dt, (s == 0) ? 64'(p_cut_ang) : 64'(p_cut_lin)));
      xi = (s == 0) ? 64'(p_damp_ang) : 64'(p_damp_lin);
      c[s][0] = longint'((k * k + 64'd32768) >> 16);
      kx = longint'((k * xi + 64'd8192) >> 14);
      c[s][1] = 131072 - 2 * kx;
      c[s][2] = 65536 - c[s][0] - c[s][1];
    end
    for (int ch = 0; ch < NCH; ch++) begin
      g = (ch < 3 || (ch >= 6 && ch < 10)) ? 0 : 1;
      xin = (ch < 6) ? longint'($signed(v[ch])) : p_pose[ch - 6];
      acc = c[g][0] * xin + c[g][1] * p_y1[ch] + c[g][2] * p_y2[ch] + 32768;
      y = acc >>> 16;
      res.clip = 1'b0;
      if (y > 64'sh7FFF_FFFF) begin y = 64'sh7FFF_FFFF; res.clip = 1'b1; end
      if (y < -64'sh8000_0000) begin y = -64'sh8000_0000; res.clip = 1'b1; end
      p_y2[ch] = p_y1[ch];
      p_y1[ch] = y;
      res.ch = sol_pkg::CH_W'(ch);
      res.val = y[31:0];
      res.last = (ch == NCH - 1);
      pending_res.push_back(res);
    end
  endtask

  // sink side: stall pattern and result check
  always @(posedge clk) begin
    chan_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_res.size() == 0) begin
          report_mismatch("unexpected beat channel", longint'(out_tuser[3:0]), 0);
        end else begin
          want = pending_res.pop_front();
          if (out_tuser[3:0] !== want.ch)
            report_mismatch("channel", longint'(out_tuser[3:0]), longint'(want.ch));
          if (out_tdata !== want.val)
            report_mismatch("filtered", longint'(out_tdata), longint'(want.val));
          if (out_tuser[4] !== want.clip)
            report_mismatch("clipped", longint'(out_tuser[4]), longint'(want.clip));
          if (out_tlast !== want.last)
            report_mismatch("last", longint'(out_tlast), longint'(want.last));
        end
      end
      if (out_hold > 0) begin
        out_tready <= 1'b0;
        out_hold <= out_hold - 1;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) out_hold <= gap_len();
      end
    end
  end

  task automatic send_beat(logic kind, logic [TIME_W-1:0] t, logic [31:0] v[NVAL]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {v[6], v[5], v[4], v[3], v[2], v[1], v[0], t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(kind, t, v);
  endtask

  task automatic send_pose();
    logic [31:0] v[NVAL];
    for (int i = 0; i < NVAL; i++) v[i] = rand_val();
    send_beat(sol_pkg::KIND_POSE, TIME_W'({$urandom(), $urandom()}), v);
  endtask

  task automatic send_twist(logic [TIME_W-1:0] t);
    logic [31:0] v[NVAL];
    for (int i = 0; i < NVAL; i++) v[i] = rand_val();
    send_beat(sol_pkg::KIND_TWIST, t, v);
  endtask

  function automatic logic [TIME_W-1:0] good_time();
    logic [TIME_W-1:0] dt;
    case ($urandom_range(0, 9))
      0: dt = TIME_W'({$urandom_range(0, 255), $urandom()});
      1: dt = TIME_W'(1);
      default: dt = TIME_W'($urandom_range(1, 200000));
    endcase
    return p_last_time + TIME_W'(p_min_int) + dt;
  endfunction

  function automatic logic [TIME_W-1:0] bad_time();
    if ($urandom_range(0, 1) == 0 || p_last_time == 0)
      return p_last_time + TIME_W'($urandom_range(0, 32'(p_min_int)));
    return p_last_time - TIME_W'($urandom_range(0, 1000));
  endfunction

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [sol_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sol_pkg::CFG_CUTOFF_ANG: p_cut_ang = data[15:0];
      sol_pkg::CFG_CUTOFF_LIN: p_cut_lin = data[15:0];
      sol_pkg::CFG_DAMP_ANG:   p_damp_ang = data[14:0];
      sol_pkg::CFG_DAMP_LIN:   p_damp_lin = data[14:0];
      sol_pkg::CFG_MIN_INT:    p_min_int = data;
      default: ;
    endcase
  endtask

  task automatic send_mixed(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_pose();
      else if (r < 85) send_twist(good_time());
      else send_twist(bad_time());
    end
  endtask

  task automatic test_directed();
    logic [31:0] v[NVAL];
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000,
          32'hFFFF_0000};
    send_beat(sol_pkg::KIND_POSE, '1, v);
    send_twist('0);                   // equal to last time, rejected
    send_twist(TIME_W'(31250));       // within min interval, rejected
    send_beat(sol_pkg::KIND_TWIST, TIME_W'(31251), v);  // first twist, dt is the timestamp
    send_twist(TIME_W'(31251));       // same time, rejected
    send_twist(TIME_W'(100));         // backwards, rejected
    v = '{default: 32'h7FFF_FFFF};
    send_beat(sol_pkg::KIND_POSE, '0, v);
    for (int i = 0; i < 3; i++)
      send_beat(sol_pkg::KIND_TWIST, p_last_time + TIME_W'(100000), v);
    send_beat(sol_pkg::KIND_TWIST, p_last_time + 48'h10_0000_0000, v);  // k saturates
    v = '{default: 32'h8000_0000};
    send_beat(sol_pkg::KIND_POSE, '0, v);
    for (int i = 0; i < 3; i++)
      send_beat(sol_pkg::KIND_TWIST, p_last_time + TIME_W'(40000), v);
    send_beat(sol_pkg::KIND_TWIST, p_last_time + TIME_W'(5000000), v);
    v = '{default: 32'h0};
    send_beat(sol_pkg::KIND_TWIST, p_last_time + TIME_W'(31251), v);
  endtask

  task automatic test_config_sweep();
    logic [23:0] sets[5][5];
    sets[0] = '{default: 24'h0};
    sets[1] = '{24'h00FFFF, 24'h00FFFF, 24'h007FFF, 24'h007FFF, 24'hFF_FFFF};
    sets[2] = '{24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
                24'($urandom_range(0, 32767)), 24'($urandom_range(0, 32767)),
                24'($urandom_range(0, 100000))};
    sets[3] = '{24'h000100, 24'h00FFFF, 24'h000000, 24'h007FFF, 24'h000001};
    sets[4] = '{24'd2560, 24'd853, 24'd15729, 24'd15729, 24'd31250};
    for (int s = 0; s < 5; s++) begin
      wait_idle();
      write_reg(sol_pkg::CFG_CUTOFF_ANG, sets[s][0]);
      write_reg(sol_pkg::CFG_CUTOFF_LIN, sets[s][1]);
      write_reg(sol_pkg::CFG_DAMP_ANG, sets[s][2]);
      write_reg(sol_pkg::CFG_DAMP_LIN, sets[s][3]);
      write_reg(sol_pkg::CFG_MIN_INT, sets[s][4]);
      if (s == 2) begin
        write_reg(CFG_NONE_LO, 24'($urandom()));
        write_reg(CFG_NONE_HI, 24'hFF_FFFF);
      end
      cfg_valid <= 1'b0;
      send_mixed(20);
    end
  endtask

  task automatic test_random();
    send_mixed(70);
    calm = 1'b1;
    send_mixed(30);
    calm = 1'b0;
    send_mixed(70);
  endtask

  task automatic test_time_top();
    send_twist('1);
    for (int i = 0; i < 4; i++) send_twist(TIME_W'({$urandom(), $urandom()}));
  endtask

  initial begin
    p_cut_ang = 16'd2560;
    p_cut_lin = 16'd853;
    p_damp_ang = 15'd15729;
    p_damp_lin = 15'd15729;
    p_min_int = 24'd31250;
    p_last_time = '0;
    for (int i = 0; i < NVAL; i++) p_pose[i] = 0;
    for (int i = 0; i < NCH; i++) begin
      p_y1[i] = 0;
      p_y2[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    test_time_top();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
